// ===== rtl/ipv6_text_address_parser_defines.svh =====
// assertion macros for the ipv6 text address parser
`ifndef IPV6_TEXT_ADDRESS_PARSER_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_DEFINES_SVH

// same-cycle implication
`define IPV6TP_AST_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPV6TP_AST_NXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ipv6tp_pkg.sv =====
// shared types and constants for the ipv6 text address parser
`default_nettype none

package ipv6tp_pkg;

  localparam int NumGroups = 8;
  localparam int MaxDigits = 4;
  localparam int QueueDepth = 2;
  localparam logic [7:0] ColonCode = 8'h3a;

  typedef struct packed {
    logic             ok;
    logic [3:0]       n;
    logic [3:0]       k;
    logic [7:0][15:0] grp;
  } ipv6tp_rec_t;

endpackage

`default_nettype wire

// ===== rtl/ipv6tp_front.sv =====
// character front end: group building, gap tracking and error checks
`default_nettype none

module ipv6tp_front import ipv6tp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  char_code,
  input  wire logic        last,
  output ipv6tp_rec_t      rec,
  output logic             rec_vld
);

  logic [7:0][15:0] grp_r, grp_nxt;
  logic [3:0]  gdone_r, gdone_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [2:0]  digits_r, digits_nxt;
  logic [3:0]  gap_place_r, gap_place_nxt;
  logic        gap_seen_r, gap_seen_nxt;
  logic        failed_r, failed_nxt;
  logic        at_start_r, at_start_nxt;
  logic        lead_r, lead_nxt;

  logic        is_dec, is_lc, is_uc, is_hex, is_colon;
  logic [3:0]  hex_val;
  logic        take, push_req;
  logic [3:0]  k_raw;

  assign is_dec   = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_lc    = (char_code >= 8'h61) && (char_code <= 8'h66);
  assign is_uc    = (char_code >= 8'h41) && (char_code <= 8'h46);
  assign is_hex   = is_dec || is_lc || is_uc;
  assign is_colon = (char_code == ColonCode);
  assign hex_val  = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);

  always_comb begin
    grp_nxt       = grp_r;
    gdone_nxt     = gdone_r;
    accum_nxt     = accum_r;
    digits_nxt    = digits_r;
    gap_place_nxt = gap_place_r;
    gap_seen_nxt  = gap_seen_r;
    failed_nxt    = failed_r;
    lead_nxt      = lead_r;
    at_start_nxt  = 1'b0;
    take          = 1'b0;
    push_req      = 1'b0;
    k_raw         = 4'(NumGroups);
    rec           = '0;
    rec_vld       = acc && last;

    if (!failed_r) begin
      if (at_start_r) begin
        if (is_colon) begin
          lead_nxt = 1'b1;
          if (last) failed_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end
      end else if (lead_r) begin
        lead_nxt = 1'b0;
        if (!is_colon) failed_nxt = 1'b1;
        else take = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      if (is_hex) begin
        if (digits_r >= 3'(MaxDigits)) begin
          failed_nxt = 1'b1;
        end else begin
          accum_nxt  = {accum_r[11:0], hex_val};
          digits_nxt = digits_r + 3'd1;
        end
      end else if (is_colon) begin
        if (digits_r == 3'd0) begin
          if (gap_seen_r) begin
            failed_nxt = 1'b1;
          end else begin
            gap_seen_nxt  = 1'b1;
            gap_place_nxt = gdone_r;
          end
        end else if (last) begin
          failed_nxt = 1'b1;
        end else begin
          push_req = 1'b1;
        end
      end else begin
        failed_nxt = 1'b1;
      end
    end

    if (last && !failed_nxt && (digits_nxt != 3'd0)) push_req = 1'b1;

    if (push_req) begin
      if (gdone_r >= 4'(NumGroups)) begin
        failed_nxt = 1'b1;
      end else begin
        grp_nxt[gdone_r[2:0]] = accum_nxt;
        gdone_nxt  = gdone_r + 4'd1;
        accum_nxt  = '0;
        digits_nxt = '0;
      end
    end

    if (last) begin
      if (!failed_nxt && gap_seen_nxt && (gdone_nxt >= 4'(NumGroups))) failed_nxt = 1'b1;
      if (!failed_nxt && !gap_seen_nxt && (gdone_nxt != 4'(NumGroups))) failed_nxt = 1'b1;
      if (gap_seen_nxt) k_raw = gap_place_nxt;
      rec.ok  = !failed_nxt;
      rec.n   = gdone_nxt;
      rec.k   = (k_raw > gdone_nxt) ? gdone_nxt : k_raw;
      rec.grp = grp_nxt;

      grp_nxt       = '0;
      gdone_nxt     = '0;
      accum_nxt     = '0;
      digits_nxt    = '0;
      gap_place_nxt = '0;
      gap_seen_nxt  = 1'b0;
      failed_nxt    = 1'b0;
      lead_nxt      = 1'b0;
      at_start_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= '0;
      gdone_r     <= '0;
      accum_r     <= '0;
      digits_r    <= '0;
      gap_place_r <= '0;
      gap_seen_r  <= 1'b0;
      failed_r    <= 1'b0;
      at_start_r  <= 1'b1;
      lead_r      <= 1'b0;
    end else if (acc) begin
      grp_r       <= grp_nxt;
      gdone_r     <= gdone_nxt;
      accum_r     <= accum_nxt;
      digits_r    <= digits_nxt;
      gap_place_r <= gap_place_nxt;
      gap_seen_r  <= gap_seen_nxt;
      failed_r    <= failed_nxt;
      at_start_r  <= at_start_nxt;
      lead_r      <= lead_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ipv6tp_fifo.sv =====
// short record queue between front end and expansion stage
`default_nettype none

module ipv6tp_fifo import ipv6tp_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr,
  input  wire ipv6tp_rec_t wdata,
  output logic             full,
  input  wire logic        rd,
  output ipv6tp_rec_t      rdata,
  output logic             empty
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  ipv6tp_rec_t    mem [Depth];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == CW'(Depth));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == PW'(Depth - 1)) ? '0 : wp_r + PW'(1);
    if (do_rd) rp_nxt = (rp_r == PW'(Depth - 1)) ? '0 : rp_r + PW'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    if (!do_wr && do_rd) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wdata;
  end

endmodule

`default_nettype wire

// ===== rtl/ipv6tp_back.sv =====
// gap expansion and result output register
`default_nettype none

module ipv6tp_back import ipv6tp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ipv6tp_rec_t  rec,
  input  wire logic         q_empty,
  output logic              q_rd,
  output logic              empty,
  input  wire logic         pop,
  output logic              valid_res,
  output logic [63:0]       addr_high,
  output logic [63:0]       addr_low
);

  logic         vld_r;
  logic         ok_r;
  logic [127:0] addr_r, addr_nxt;
  logic [3:0]   fill;
  logic [4:0]   gap_end;
  logic [2:0]   src;

  assign fill    = 4'(NumGroups) - rec.n;
  assign gap_end = {1'b0, rec.k} + {1'b0, fill};
  assign q_rd    = !q_empty && (!vld_r || pop);

  always_comb begin
    addr_nxt = '0;
    src      = '0;
    for (int i = 0; i < NumGroups; i++) begin
      src = 3'(i - int'(fill));
      if (i < int'(rec.k)) begin
        addr_nxt[(NumGroups-1-i)*16 +: 16] = rec.grp[i];
      end else if (i >= int'(gap_end)) begin
        addr_nxt[(NumGroups-1-i)*16 +: 16] = rec.grp[src];
      end
    end
    if (!rec.ok) addr_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_rd) begin
      vld_r <= 1'b1;
    end else if (pop) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      ok_r   <= rec.ok;
      addr_r <= addr_nxt;
    end
  end

  assign empty     = !vld_r;
  assign valid_res = ok_r;
  assign addr_high = addr_r[127:64];
  assign addr_low  = addr_r[63:0];

endmodule

`default_nettype wire

// ===== rtl/ipv6_text_address_parser.sv =====
// top level of the ipv6 text address parser
// Takes one ASCII character per beat and, on the beat flagged last, queues one
// result: a valid flag and the 128-bit address (zero when the text is rejected),
// with any '::' gap expanded to zero groups. A new character is accepted every
// cycle while full is low; full rises only when the record queue between the
// character front end and the expansion stage holds QDEPTH finished addresses
// that have not moved on to the output register. A queued result is loaded into
// the output register when that register is free or being popped. Dotted IPv4
// tails are rejected.
`default_nettype none

module ipv6_text_address_parser import ipv6tp_pkg::*; #(
  parameter int QDEPTH = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_valid_res,
  output logic [63:0]      out_addr_high,
  output logic [63:0]      out_addr_low
);

  ipv6tp_rec_t f_rec, q_rec;
  logic        f_rec_vld;
  logic        q_empty, q_rd;
  logic        in_acc;

  assign in_acc = push && !full;

  ipv6tp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .char_code (in_char_code),
    .last      (in_last),
    .rec       (f_rec),
    .rec_vld   (f_rec_vld)
  );

  ipv6tp_fifo #(.Depth(QDEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (f_rec_vld),
    .wdata (f_rec),
    .full  (full),
    .rd    (q_rd),
    .rdata (q_rec),
    .empty (q_empty)
  );

  ipv6tp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (q_rec),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .empty     (empty),
    .pop       (pop),
    .valid_res (out_valid_res),
    .addr_high (out_addr_high),
    .addr_low  (out_addr_low)
  );

endmodule

`default_nettype wire

// ===== rtl/ipv6tp_checker.sv =====
// port-level checks for the ipv6 text address parser and their binding
`default_nettype none
`include "ipv6_text_address_parser_defines.svh"

module ipv6tp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        out_valid_res,
  input wire logic [63:0] out_addr_high,
  input wire logic [63:0] out_addr_low
);

  `IPV6TP_AST_IMP(a_zero_when_bad, clk, !rst_n, !empty && !out_valid_res, (out_addr_high == 64'd0) && (out_addr_low == 64'd0), "rejected beat carries nonzero address")
  `IPV6TP_AST_NXT(a_rst_empty, clk, 1'b0, !rst_n, empty && !full, "queues not clear after reset")
  `IPV6TP_AST_NXT(a_hold, clk, !rst_n, !empty && !pop, !empty && $stable(out_addr_high) && $stable(out_addr_low) && $stable(out_valid_res), "stalled result beat changed")
  `IPV6TP_AST_NXT(a_no_full_from_idle, clk, !rst_n, !full && !push, !full, "full rose without an accepted beat")

endmodule

bind ipv6_text_address_parser ipv6tp_checker u_ipv6tp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_valid_res (out_valid_res),
  .out_addr_high (out_addr_high),
  .out_addr_low  (out_addr_low)
);

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the ipv6 text address parser, directed and random address texts
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import ipv6tp_pkg::*;

  typedef struct {
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_result_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_char_code;
  logic        in_last;
  logic        empty;
  logic        pop;
  logic        out_valid_res;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;

  addr_result_t expected_addrs[$];
  logic [7:0]   text_buf[$];
  int           mismatches = 0;
  int           beats_sent = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;

  logic [15:0] grp_q[8];
  logic [3:0]  n_done;
  logic [15:0] acc;
  logic [2:0]  ndig;
  logic [3:0]  gap_at;
  bit          gap_hit;
  bit          bad;
  bit          first_char;
  bit          lead_colon;

  ipv6_text_address_parser uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_char_code  (in_char_code),
    .in_last       (in_last),
    .empty         (empty),
    .pop           (pop),
    .out_valid_res (out_valid_res),
    .out_addr_high (out_addr_high),
    .out_addr_low  (out_addr_low)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic clear_parser();
    for (int i = 0; i < NumGroups; i++) grp_q[i] = '0;
    n_done = '0;
    acc = '0;
    ndig = '0;
    gap_at = '0;
    gap_hit = 1'b0;
    bad = 1'b0;
    first_char = 1'b1;
    lead_colon = 1'b0;
  endtask

  task automatic close_group();
    if (n_done >= NumGroups) begin
      bad = 1'b1;
    end else begin
      grp_q[n_done[2:0]] = acc;
      n_done++;
      acc = '0;
      ndig = '0;
    end
  endtask

  task automatic absorb_char(input logic [7:0] c, input bit is_last);
    int d;
    d = hex_nibble(c);
    if (d >= 0) begin
      if (ndig >= MaxDigits) begin
        bad = 1'b1;
      end else begin
        acc = {acc[11:0], 4'(d)};
        ndig++;
      end
    end else if (c == ColonCode) begin
      if (ndig == 0) begin
        if (gap_hit) begin
          bad = 1'b1;
        end else begin
          gap_hit = 1'b1;
          gap_at = n_done;
        end
      end else if (is_last) begin
        bad = 1'b1;
      end else begin
        close_group();
      end
    end else begin
      bad = 1'b1;
    end
  endtask

  task automatic predict_address(input logic [7:0] c, input bit is_last);
    addr_result_t r;
    int           n;
    int           k;
    int           fill;
    logic [15:0]  g;
    logic [127:0] word;
    if (!bad) begin
      if (first_char) begin
        if (c == ColonCode) begin
          lead_colon = 1'b1;
          if (is_last) bad = 1'b1;
        end else begin
          absorb_char(c, is_last);
        end
      end else if (lead_colon) begin
        lead_colon = 1'b0;
        if (c != ColonCode) bad = 1'b1;
        else absorb_char(c, is_last);
      end else begin
        absorb_char(c, is_last);
      end
    end
    first_char = 1'b0;
    if (is_last) begin
      if (!bad && ndig > 0) close_group();
      if (!bad && gap_hit && n_done >= NumGroups) bad = 1'b1;
      if (!bad && !gap_hit && n_done != NumGroups) bad = 1'b1;
      word = '0;
      if (!bad) begin
        n = n_done;
        k = gap_hit ? int'(gap_at) : NumGroups;
        fill = NumGroups - n;
        if (k > n) k = n;
        for (int i = 0; i < NumGroups; i++) begin
          if (i < k) g = grp_q[i];
          else if (i < k + fill) g = '0;
          else g = grp_q[i - fill];
          word = {word[111:0], g};
        end
      end
      r.ok = !bad;
      r.hi = word[127:64];
      r.lo = word[63:0];
      expected_addrs.push_back(r);
      clear_parser();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input bit is_last);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_char_code <= c;
    in_last <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    predict_address(c, is_last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  task automatic add_group(input int digits);
    int v;
    for (int i = 0; i < digits; i++) begin
      v = $urandom_range(15);
      if (v < 10) text_buf.push_back(8'("0" + v));
      else if ($urandom_range(1)) text_buf.push_back(8'("A" + v - 10));
      else text_buf.push_back(8'("a" + v - 10));
    end
  endtask

  task automatic build_text();
    int  kind;
    int  total;
    int  gap_pos;
    int  pos;
    bit  gap;
    kind = $urandom_range(99);
    text_buf.delete();
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
      return;
    end
    gap = $urandom_range(1);
    if (kind < 80) total = gap ? $urandom_range(7) : NumGroups;
    else total = $urandom_range(9);
    gap_pos = gap ? $urandom_range(total) : total;
    for (int i = 0; i < total; i++) begin
      if (gap && i == gap_pos) begin
        text_buf.push_back(ColonCode);
        text_buf.push_back(ColonCode);
      end else if (i > 0) begin
        text_buf.push_back(ColonCode);
      end
      add_group((kind >= 80 && $urandom_range(9) == 0) ? 5 : $urandom_range(1, 4));
    end
    if (gap && gap_pos == total) begin
      text_buf.push_back(ColonCode);
      text_buf.push_back(ColonCode);
    end
    if (kind >= 80) begin
      pos = (text_buf.size() > 0) ? $urandom_range(text_buf.size() - 1) : 0;
      case ($urandom_range(5))
        1: if (text_buf.size() > 0) text_buf[pos] = 8'($urandom_range(255));
        2: text_buf.insert(pos, 8'($urandom_range(255)));
        3: text_buf.push_front(ColonCode);
        4: text_buf.push_back(ColonCode);
        5: if (text_buf.size() > 0) text_buf.delete(pos);
        default: ;
      endcase
    end
    if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (expected_addrs.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_addrs.size() > 0) begin
      report_mismatch("results never arrived", 64'(expected_addrs.size()), 64'd0);
      expected_addrs.delete();
    end
  endtask

  task automatic run_addresses(input int idle, input int stall, input int beats,
                               input bit pause_midway);
    int start;
    bit paused;
    idle_pct = idle;
    stall_pct = stall;
    start = beats_sent;
    paused = 1'b0;
    while (beats_sent - start < beats) begin
      build_text();
      send_text();
      if (pause_midway && !paused && beats_sent - start >= beats / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
    drain_results();
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_string("::");
    send_string(":1");
    send_string(":");
    send_string("aBcD0");
    send_string(":::");
    send_string("1:");
    send_string("1:2");
    send_string("g");
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    send_string("F::");
    drain_results();
  endtask

  task automatic test_back_to_back();
    run_addresses(0, 0, 240, 1'b0);
  endtask

  task automatic test_sender_gaps();
    run_addresses(51, 0, 240, 1'b0);
  endtask

  task automatic test_receiver_stalls();
    run_addresses(0, 51, 240, 1'b0);
  endtask

  task automatic test_mixed_idling_with_pause();
    run_addresses(36, 36, 240, 1'b1);
  endtask

  // result checker
  initial begin
    addr_result_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (expected_addrs.size() == 0) begin
          report_mismatch("unexpected result beat", out_addr_high, 64'd0);
        end else begin
          want = expected_addrs.pop_front();
          if (out_valid_res !== want.ok)
            report_mismatch("valid_res", 64'(out_valid_res), 64'(want.ok));
          if (out_addr_high !== want.hi) report_mismatch("addr_high", out_addr_high, want.hi);
          if (out_addr_low !== want.lo) report_mismatch("addr_low", out_addr_low, want.lo);
        end
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_char_code <= 8'h00;
    in_last <= 1'b0;
    clear_parser();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling_with_pause();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
